// ===== rtl/tsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

   // Fixed field widths
   localparam int THRESH_W      = 24;
   localparam int TICK_W        = 16;
   localparam int OUT_COUNT_W   = 24;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   // Default width of the interval counter
   localparam int COUNT_WIDTH_DEF = 24;

   localparam logic [TICK_W-1:0] INTERVAL_RESET = 16'd1000;

   // Register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_TRAFFIC_MODE   = 2'd0;
   localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd2;
   localparam logic [1:0] REG_INTERVAL_TICKS = 2'd3;

   // Controlled traffic class
   localparam logic [1:0] MODE_NONE      = 2'd0;
   localparam logic [1:0] MODE_BCAST     = 2'd1;
   localparam logic [1:0] MODE_MCAST     = 2'd2;
   localparam logic [1:0] MODE_UNK_UCAST = 2'd3;

   // Packet kinds
   localparam logic [1:0] KIND_BCAST = 2'd0;
   localparam logic [1:0] KIND_MCAST = 2'd1;

   // Item actions
   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   typedef struct packed {
      logic       action;
      logic       on_watched_port;
      logic [1:0] packet_kind;
      logic       route_miss;
   } req_type;

   typedef struct packed {
      logic                   drop;
      logic                   blocking;
      logic [OUT_COUNT_W-1:0] interval_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          traffic_mode;
      logic [THRESH_W-1:0] high_threshold;
      logic [THRESH_W-1:0] release_level;
      logic [TICK_W-1:0]   interval_ticks;
   } tsl_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/tsl_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tsl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tsl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tsl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output tsl_pkg::tsl_cfg_type             cfg
);
   import tsl_pkg::*;

   logic [1:0]          traffic_mode_ff,   traffic_mode_in;
   logic [THRESH_W-1:0] high_threshold_ff, high_threshold_in;
   logic [THRESH_W-1:0] release_level_ff,  release_level_in;
   logic [TICK_W-1:0]   interval_ticks_ff, interval_ticks_in;
   logic                wr_en;
   logic [1:0]          reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      traffic_mode_in   = traffic_mode_ff;
      high_threshold_in = high_threshold_ff;
      release_level_in  = release_level_ff;
      interval_ticks_in = interval_ticks_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TRAFFIC_MODE:   traffic_mode_in   = csr_pwdata[1:0];
            REG_HIGH_THRESHOLD: high_threshold_in = csr_pwdata[THRESH_W-1:0];
            REG_LOW_THRESHOLD:  release_level_in  = csr_pwdata[THRESH_W-1:0];
            REG_INTERVAL_TICKS: interval_ticks_in = csr_pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         traffic_mode_ff   <= MODE_NONE;
         high_threshold_ff <= '0;
         release_level_ff  <= '0;
         interval_ticks_ff <= INTERVAL_RESET;
      end else begin
         traffic_mode_ff   <= traffic_mode_in;
         high_threshold_ff <= high_threshold_in;
         release_level_ff  <= release_level_in;
         interval_ticks_ff <= interval_ticks_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TRAFFIC_MODE:   csr_prdata = CSR_DATA_W'(traffic_mode_ff);
         REG_HIGH_THRESHOLD: csr_prdata = CSR_DATA_W'(high_threshold_ff);
         REG_LOW_THRESHOLD:  csr_prdata = CSR_DATA_W'(release_level_ff);
         REG_INTERVAL_TICKS: csr_prdata = CSR_DATA_W'(interval_ticks_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.traffic_mode   = traffic_mode_ff;
   assign cfg.high_threshold = high_threshold_ff;
   assign cfg.release_level  = release_level_ff;
   assign cfg.interval_ticks = interval_ticks_ff;

endmodule

`default_nettype wire

// ===== rtl/tsl_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_engine #(
   parameter int COUNT_WIDTH = tsl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tsl_pkg::req_type     item,
   input  tsl_pkg::tsl_cfg_type cfg,
   output tsl_pkg::rsp_type     result
);
   import tsl_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

   logic [COUNT_WIDTH-1:0] window_count_ff, window_count_in;
   logic                   blocking_ff,     blocking_in;
   logic                   timer_running_ff, timer_running_in;
   logic [TICK_W-1:0]      tick_count_ff,   tick_count_in;

   logic              class_match;
   logic              counted;
   logic [TICK_W:0]   tick_inc;
   logic [TICK_W-1:0] limit;
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  count_out;

   always_comb begin
      case (cfg.traffic_mode)
         MODE_BCAST:     class_match = (item.packet_kind == KIND_BCAST);
         MODE_MCAST:     class_match = (item.packet_kind == KIND_MCAST);
         MODE_UNK_UCAST: class_match = (item.packet_kind != KIND_BCAST) &&
                                       (item.packet_kind != KIND_MCAST) &&
                                       item.route_miss;
         default:        class_match = 1'b0;
      endcase
   end

   assign counted   = (item.action == ACT_PACKET) & item.on_watched_port & class_match;
   assign limit     = (cfg.interval_ticks == '0) ? TICK_W'(1) : cfg.interval_ticks;
   assign tick_inc  = {1'b0, tick_count_ff} + 1'b1;
   assign count_ext = CMP_W'(window_count_ff);

   always_comb begin
      window_count_in  = window_count_ff;
      blocking_in      = blocking_ff;
      timer_running_in = timer_running_ff;
      tick_count_in    = tick_count_ff;
      if (counted) begin
         if (!timer_running_ff && !blocking_ff) begin
            timer_running_in = 1'b1;
            tick_count_in    = '0;
         end
         if (window_count_ff != '1) begin
            window_count_in = window_count_ff + 1'b1;
         end
      end else if (item.action == ACT_TICK && timer_running_ff) begin
         if (tick_inc >= {1'b0, limit}) begin
            // interval over: apply hysteresis and restart the count
            tick_count_in = '0;
            if (!blocking_ff) begin
               blocking_in = (count_ext >= CMP_W'(cfg.high_threshold));
            end else begin
               blocking_in = !(count_ext < CMP_W'(cfg.release_level));
            end
            window_count_in = '0;
         end else begin
            tick_count_in = tick_inc[TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff  <= '0;
         blocking_ff      <= 1'b0;
         timer_running_ff <= 1'b0;
         tick_count_ff    <= '0;
      end else if (advance) begin
         window_count_ff  <= window_count_in;
         blocking_ff      <= blocking_in;
         timer_running_ff <= timer_running_in;
         tick_count_ff    <= tick_count_in;
      end
   end

   assign count_out             = CMP_W'(window_count_in);
   assign result.drop           = counted & blocking_ff;
   assign result.blocking       = blocking_in;
   assign result.interval_count = count_out[OUT_COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/traffic_storm_limiter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An accepted beat waits in the input stage, then moves to the result stage and rsp_
// once that stage is empty or draining. Throughput: one beat per cycle on both channels
// while rsp_stall is low; set by the single state update (counter increment and one
// threshold compare) between input and result register. Reset (synchronous, active
// high) empties both stages, clears count, blocking, timer and tick count, and loads
// the registers with mode none, thresholds zero and an interval of 1000 ticks.
module traffic_storm_limiter_core #(
   parameter int COUNT_WIDTH = tsl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tsl_pkg::req_type               req_data,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tsl_pkg::rsp_type               rsp_data,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tsl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tsl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tsl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tsl_pkg::*;

   tsl_cfg_type cfg;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;

   logic req_take;
   logic advance;

   tsl_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance the held beat whenever the result register is empty or being drained.
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   // Stall only when both stages are full and the sink holds off.
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance  | (out_valid_ff & rsp_stall);

   tsl_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: capture on handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tsl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsl_pkg::rsp_type rsp_data
);
   import tsl_pkg::*;

   // Results come out of a reset block empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // A dropped packet is only ever reported while blocking.
   a_drop_blocking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drop |-> rsp_data.blocking)
      else $error("drop without blocking");

   // The input side stalls only when the result side is full and held off.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without downstream backpressure");

   // A held result beat does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind traffic_storm_limiter_core tsl_checker u_checker (.*);

`default_nettype wire

// ===== tb/storm_limit_checker.sv =====
`timescale 1ns / 1ps

module storm_limit_checker #(
   parameter int COUNT_WIDTH = tsl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  tsl_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  tsl_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tsl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tsl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             error_count,
   output int                             outstanding
);
   import tsl_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_CEIL = '1;

   // shadow registers
   logic [1:0]          class_sel;
   logic [THRESH_W-1:0] start_level;
   logic [THRESH_W-1:0] stop_level;
   logic [TICK_W-1:0]   ticks_per_window;

   // limiter state
   logic [COUNT_WIDTH-1:0] window_pkts;
   logic                   blocked;
   logic                   timer_live;
   int unsigned            ticks_seen;

   rsp_type verdict_q[$];
   int      fault_tally = 0;

   function automatic logic class_hit(input req_type item);
      case (class_sel)
         MODE_BCAST:     return item.packet_kind == KIND_BCAST;
         MODE_MCAST:     return item.packet_kind == KIND_MCAST;
         MODE_UNK_UCAST: return item.packet_kind != KIND_BCAST &&
                                item.packet_kind != KIND_MCAST && item.route_miss;
         default:        return 1'b0;
      endcase
   endfunction

   // Advance the limiter by one beat and return the verdict it produces.
   function automatic rsp_type step_limiter(input req_type item);
      rsp_type     outcome;
      int unsigned window_len;
      outcome = '0;
      if (item.action == ACT_PACKET) begin
         if (item.on_watched_port && class_hit(item)) begin
            if (!timer_live && !blocked) begin
               timer_live = 1'b1;
               ticks_seen = 0;
            end
            if (window_pkts != COUNT_CEIL) window_pkts = window_pkts + 1'b1;
            outcome.drop = blocked;
         end
      end else if (timer_live) begin
         window_len = (ticks_per_window == '0) ? 1 : ticks_per_window;
         ticks_seen++;
         if (ticks_seen >= window_len) begin
            ticks_seen = 0;
            if (!blocked) blocked = (window_pkts >= start_level);
            else blocked = (window_pkts >= stop_level);
            window_pkts = '0;
         end
      end
      outcome.blocking       = blocked;
      outcome.interval_count = OUT_COUNT_W'(window_pkts);
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         class_sel        = MODE_NONE;
         start_level      = '0;
         stop_level       = '0;
         ticks_per_window = INTERVAL_RESET;
         window_pkts      = '0;
         blocked          = 1'b0;
         timer_live       = 1'b0;
         ticks_seen       = 0;
         verdict_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_TRAFFIC_MODE:   class_sel        = csr_pwdata[1:0];
               REG_HIGH_THRESHOLD: start_level      = csr_pwdata[THRESH_W-1:0];
               REG_LOW_THRESHOLD:  stop_level       = csr_pwdata[THRESH_W-1:0];
               REG_INTERVAL_TICKS: ticks_per_window = csr_pwdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) verdict_q.push_back(step_limiter(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               fault_tally++;
               if (fault_tally <= 10)
                  $display("%0t: unexpected result beat drop=%0b blocking=%0b count=%0d",
                           $realtime, rsp_data.drop, rsp_data.blocking,
                           rsp_data.interval_count);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.drop !== want.drop || rsp_data.blocking !== want.blocking ||
                   rsp_data.interval_count !== want.interval_count) begin
                  fault_tally++;
                  if (fault_tally <= 10)
                     $display("%0t: mismatch expected drop=%0b blocking=%0b count=%0d, %s",
                              $realtime, want.drop, want.blocking, want.interval_count,
                              $sformatf("got drop=%0b blocking=%0b count=%0d",
                                        rsp_data.drop, rsp_data.blocking,
                                        rsp_data.interval_count));
               end
            end
         end
      end
      error_count <= fault_tally;
      outstanding <= verdict_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tsl_pkg::*;

   // Cycles without any accepted beat before the run is called hung.
   localparam int IDLE_LIMIT  = 1000;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 140;
   // Extra idle pause after the last result has arrived.
   localparam int DRAIN_PAUSE = 6;
   localparam int REQ_W       = $bits(req_type);

   // Kinds that fall in the "other" bucket
   localparam logic [1:0] KIND_OTHER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [THRESH_W-1:0] LEVEL_MAX = '1;
   localparam logic [TICK_W-1:0]   SPAN_MAX  = '1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          fault_count;
   int          beats_in_flight;
   bit          calm_sender   = 1'b0;
   bit          calm_receiver = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned hold_draw;
   int unsigned idle_cycles   = 0;
   int unsigned tick_pct      = 30;
   logic [1:0]  mode_now      = MODE_NONE;
   int          phase_idx;
   int          beat_idx;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   traffic_storm_limiter_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   storm_limit_checker CHECK (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (fault_count),
      .outstanding (beats_in_flight)
   );

   // Result side: after each accepted result beat, draw a random stall, possibly none.
   // Skip the stall entirely while the receiver is in a calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else if (rsp_valid && !rsp_stall) begin
         hold_draw = calm_receiver ? 0 : $urandom_range(0, 4);
         hold_left <= hold_draw;
         rsp_stall <= (hold_draw != 0);
      end
   end

   // Watchdog: restart on any accepted beat, give up once idle_cycles reaches IDLE_LIMIT.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL traffic_storm_limiter_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Write one register: setup cycle, then access until pready. Junk above the
   // field width goes along to exercise masking. Drop psel again afterwards.
   task automatic write_reg(input logic [1:0] index, input int unsigned width,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = value;
      if (width < CSR_DATA_W) word = word | ($urandom() << width);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_profile(input logic [1:0] mode, input logic [THRESH_W-1:0] hi,
                               input logic [THRESH_W-1:0] lo,
                               input logic [TICK_W-1:0] span);
      write_reg(REG_TRAFFIC_MODE, 2, CSR_DATA_W'(mode));
      write_reg(REG_HIGH_THRESHOLD, THRESH_W, CSR_DATA_W'(hi));
      write_reg(REG_LOW_THRESHOLD, THRESH_W, CSR_DATA_W'(lo));
      write_reg(REG_INTERVAL_TICKS, TICK_W, CSR_DATA_W'(span));
      mode_now = mode;
   endtask

   // Hold the sender until every expected result has arrived, then idle a bit
   // longer so the pipeline is empty before any register write.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_in_flight != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Present one beat after a random gap and wait for it to be taken. Valid stays
   // high after acceptance so back-to-back beats need no second assignment.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = calm_sender ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet(input logic watched, input logic [1:0] kind,
                              input logic miss);
      req_type item;
      item.action          = ACT_PACKET;
      item.on_watched_port = watched;
      item.packet_kind     = kind;
      item.route_miss      = miss;
      send_item(item);
   endtask

   // Ticks carry random junk in the packet fields; the block must ignore it.
   task automatic send_tick();
      req_type item;
      item                 = req_type'(REQ_W'($urandom()));
      item.action          = ACT_TICK;
      send_item(item);
   endtask

   // Random beat: half the packets are steered into the selected class so
   // intervals fill up and the thresholds actually get crossed.
   function automatic req_type pick_item();
      req_type item;
      item.action          = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_PACKET;
      item.on_watched_port = ($urandom_range(0, 9) != 0);
      item.packet_kind     = 2'($urandom_range(0, 3));
      item.route_miss      = 1'($urandom_range(0, 1));
      if (item.action == ACT_PACKET && $urandom_range(0, 1) == 1) begin
         case (mode_now)
            MODE_BCAST: item.packet_kind = KIND_BCAST;
            MODE_MCAST: item.packet_kind = KIND_MCAST;
            MODE_UNK_UCAST: begin
               item.packet_kind = 2'($urandom_range(KIND_OTHER, KIND_SPARE));
               item.route_miss  = 1'b1;
            end
            default: ;
         endcase
      end
      return item;
   endfunction

   // Threshold: mostly small so counts cross it, sometimes an extreme.
   function automatic logic [THRESH_W-1:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return LEVEL_MAX;
      return THRESH_W'($urandom_range(1, 8));
   endfunction

   // Interval: mostly a handful of ticks, sometimes zero (acts as one) or huge.
   function automatic logic [TICK_W-1:0] pick_span();
      int unsigned roll;
      roll = $urandom_range(0, 11);
      if (roll == 0) return '0;
      if (roll == 1) return SPAN_MAX;
      if (roll == 2) return TICK_W'($urandom_range(7, 30));
      return TICK_W'($urandom_range(1, 6));
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Broadcast class, block at 3 per interval, release below 2, 2-tick interval.
      load_profile(MODE_BCAST, 3, 2, 2);
      send_tick();                           // timer not started yet: ignored
      send_packet(1'b1, KIND_MCAST, 1'b1);   // wrong class
      send_packet(1'b0, KIND_BCAST, 1'b0);   // not on the watched port
      send_packet(1'b1, KIND_OTHER, 1'b1);   // other class
      send_packet(1'b1, KIND_BCAST, 1'b0);   // first match starts the timer
      send_packet(1'b1, KIND_BCAST, 1'b1);
      send_packet(1'b1, KIND_BCAST, 1'b0);
      send_tick();
      send_tick();                           // count 3 reaches high: block
      send_packet(1'b1, KIND_BCAST, 1'b0);   // dropped while blocking
      send_packet(1'b1, KIND_MCAST, 1'b0);   // not matched: passes
      send_tick();
      send_tick();                           // count 1 below low: release
      settle();

      // Unknown unicast with a zero interval: every tick closes an interval.
      load_profile(MODE_UNK_UCAST, 3, 2, 0);
      send_packet(1'b1, KIND_OTHER, 1'b1);
      send_packet(1'b1, KIND_SPARE, 1'b1);   // kind 3 counts as other
      send_packet(1'b1, KIND_OTHER, 1'b0);   // route hit: not counted
      send_packet(1'b1, KIND_BCAST, 1'b1);
      send_tick();
      settle();

      // Multicast, high at zero and low at its maximum: flip on every interval.
      load_profile(MODE_MCAST, '0, LEVEL_MAX, 1);
      send_packet(1'b1, KIND_MCAST, 1'b0);
      send_tick();                           // any count meets a zero high
      send_packet(1'b1, KIND_MCAST, 1'b1);   // dropped
      send_tick();                           // everything is below max low
      send_tick();
      settle();

      // No class selected: nothing matches, but the running timer keeps going.
      load_profile(MODE_NONE, LEVEL_MAX, '0, SPAN_MAX);
      send_packet(1'b1, KIND_BCAST, 1'b1);
      send_packet(1'b1, KIND_MCAST, 1'b1);
      send_packet(1'b1, KIND_SPARE, 1'b1);
      send_tick();

      // Random phases, each with its own register set and idle pattern.
      for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
         settle();
         calm_sender   = ($urandom_range(0, 3) == 0);
         calm_receiver = ($urandom_range(0, 3) == 0);
         tick_pct      = $urandom_range(10, 45);
         load_profile(($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(1, 3)),
                      pick_level(), pick_level(), pick_span());
         for (beat_idx = 0; beat_idx < PHASE_BEATS; beat_idx++) begin
            // hold the sender mid-phase until the result side has caught up
            if (phase_idx == 3 && beat_idx == PHASE_BEATS / 2) settle();
            send_item(pick_item());
         end
      end
      settle();

      if (fault_count == 0 && beats_in_flight == 0) begin
         $display("PASS traffic_storm_limiter_core");
      end else begin
         $display("FAIL traffic_storm_limiter_core");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tsl_pkg.sv
rtl/tsl_regs.sv
rtl/tsl_engine.sv
rtl/traffic_storm_limiter_core.sv
rtl/tsl_checker.sv
tb/storm_limit_checker.sv
tb/testbench.sv
